### hdl/fbfla_pkg.sv
// ----------------------------------------------------------------------------
// fbfla_pkg
// Shared types and constants for the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  // Default pool depth handed to the top level.
  localparam int unsigned MAX_BLOCKS_DEF = 256;

  // Fixed field widths.
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned GIDX_W     = 8;
  localparam int unsigned BIDX_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Operation codes; code three is a no-op.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_STATS = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NONE_USED = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR   = 2'd2;

  // Reset values.
  localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE = 17'd64;
  localparam logic [ADDR_W-1:0] RST_BASE_ADDR  = 32'd0;
  localparam int unsigned       RST_BLOCK_CNT  = 256;

  // One result item.
  typedef struct packed {
    status_e             status;
    logic [GIDX_W-1:0]   granted_index;
    logic [ADDR_W-1:0]   granted_address;
    logic [CNT_W-1:0]    blocks_free;
    logic [CNT_W-1:0]    blocks_used;
    logic [CNT_W-1:0]    peak_in_use;
    logic                all_free;
    logic                exhausted;
  } result_t;

endpackage

### hdl/fixed_block_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// An accepted item waits in the input register until the result register is
// free or being drained, then executes into the registered result.
// The next item is taken only once the last one has left the input register,
// so the registered read of the link store at the new head is current.
// Reset and every write of the block count register start a link store
// rebuild over every block of the pool; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top #(
  parameter int unsigned MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fbfla_pkg::OP_W-1:0]       op_i,
  input  logic [fbfla_pkg::BIDX_W-1:0]     block_index_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fbfla_pkg::ST_W-1:0]       status_o,
  output logic [fbfla_pkg::GIDX_W-1:0]     granted_index_o,
  output logic [fbfla_pkg::ADDR_W-1:0]     granted_address_o,
  output logic [fbfla_pkg::CNT_W-1:0]      blocks_free_o,
  output logic [fbfla_pkg::CNT_W-1:0]      blocks_used_o,
  output logic [fbfla_pkg::CNT_W-1:0]      peak_in_use_o,
  output logic                             all_free_o,
  output logic                             exhausted_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW     = $clog2(MAX_BLOCKS);
  localparam int unsigned CW     = fbfla_pkg::CNT_W;
  // Sweep counter must hold any legal block count minus one.
  localparam int unsigned SW     = (IW > CW) ? IW : CW;
  // Largest legal block count: the pool depth, capped to fit the 9-bit register.
  localparam int unsigned CapInt = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;
  localparam logic [CW:0] CapCount = (CW+1)'(CapInt);
  localparam int unsigned RstInt =
    (MAX_BLOCKS < fbfla_pkg::RST_BLOCK_CNT) ? MAX_BLOCKS : fbfla_pkg::RST_BLOCK_CNT;
  localparam logic [CW-1:0] RstCount = CW'(RstInt);
  localparam int unsigned TblN = 1 << fbfla_pkg::BIDX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0]                   count_q, count_d;
  logic [fbfla_pkg::SIZE_W-1:0]    size_q, size_d;
  logic [fbfla_pkg::ADDR_W-1:0]    base_q, base_d;
  logic                            cfg_wr;
  logic                            rebuild;
  logic [CW-1:0]                   cfg_cnt;
  logic [CW-1:0]                   cfg_cnt_clamped;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign rebuild     = cfg_wr && (cfg_index_i == fbfla_pkg::REG_BLOCK_COUNT);
  assign cfg_cnt     = cfg_data_i[CW-1:0];

  // Zero counts as one block, anything above the pool depth as the depth.
  always_comb begin
    cfg_cnt_clamped = cfg_cnt;
    if (cfg_cnt == '0) begin
      cfg_cnt_clamped = CW'(1);
    end else if ({1'b0, cfg_cnt} > CapCount) begin
      cfg_cnt_clamped = CapCount[CW-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    size_d  = size_q;
    base_d  = base_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        fbfla_pkg::REG_BLOCK_COUNT: count_d = cfg_cnt_clamped;
        fbfla_pkg::REG_BLOCK_SIZE:  size_d  = cfg_data_i[fbfla_pkg::SIZE_W-1:0];
        fbfla_pkg::REG_BASE_ADDR:   base_d  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= RstCount;
      size_q  <= fbfla_pkg::RST_BLOCK_SIZE;
      base_q  <= fbfla_pkg::RST_BASE_ADDR;
    end else begin
      count_q <= count_d;
      size_q  <= size_d;
      base_q  <= base_d;
    end
  end

  // --------------------------------------------------------------------------
  // Link store rebuild sweep: entry i gets i-1, ascending, one per cycle.
  // Only entries below the block count can be read before being written.
  // --------------------------------------------------------------------------
  logic          sweep_q, sweep_d;
  logic [SW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic          sweep_last;
  logic [IW-1:0] sweep_addr;
  logic [IW-1:0] sweep_data;

  assign sweep_last = (sweep_cnt_q == (SW'(count_q) - SW'(1)));
  assign sweep_addr = sweep_cnt_q[IW-1:0];
  assign sweep_data = (sweep_addr == '0) ? '0 : (sweep_addr - IW'(1));

  always_comb begin
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    if (rebuild) begin
      sweep_d     = 1'b1;
      sweep_cnt_d = '0;
    end else if (sweep_q) begin
      if (sweep_last) begin
        sweep_d = 1'b0;
      end else begin
        sweep_cnt_d = sweep_cnt_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
    end else begin
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input register. Only one item is in flight, so the store read of the
  // head issued at acceptance is current when the item executes.
  // --------------------------------------------------------------------------
  logic                         a_valid_q, a_valid_d;
  logic [fbfla_pkg::OP_W-1:0]   a_op_q;
  logic [IW-1:0]                a_idx_q;
  logic                         in_acc;
  logic                         b_fire;
  logic                         out_valid_q, out_valid_d;
  logic [IW-1:0]                idx_tbl [TblN];

  // block_index modulo pool depth, as a constant table.
  for (genvar g = 0; g < TblN; g++) begin : g_idx_tbl
    assign idx_tbl[g] = IW'(g % MAX_BLOCKS);
  end

  assign in_ready_o = !a_valid_q && !sweep_q;
  assign in_acc     = in_valid_i && in_ready_o;
  // Execute once the result register is free or being drained.
  assign b_fire     = a_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_acc) begin
      a_valid_d = 1'b1;
    end else if (b_fire) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_op_q  <= op_i;
      a_idx_q <= idx_tbl[block_index_i];
    end
  end

  // --------------------------------------------------------------------------
  // Free-list state and link store
  // --------------------------------------------------------------------------
  logic [IW-1:0]        head_q, head_d;
  logic [CW-1:0]        free_q, free_d;
  logic [CW-1:0]        peak_q, peak_d;
  logic [IW-1:0]        link_rd;
  logic [IW-1:0]        ex_head;
  logic [CW-1:0]        ex_free;
  logic [CW-1:0]        ex_peak;
  logic                 ex_we;
  logic [IW-1:0]        ex_waddr;
  logic [IW-1:0]        ex_wdata;
  fbfla_pkg::result_t   ex_res;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [IW-1:0]        mem_wdata;

  assign mem_we    = sweep_q || (b_fire && ex_we);
  assign mem_waddr = sweep_q ? sweep_addr : ex_waddr;
  assign mem_wdata = sweep_q ? sweep_data : ex_wdata;

  fbfla_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (head_q),
    .rdata_o (link_rd)
  );

  fbfla_exec #(
    .IDX_W (IW)
  ) u_exec (
    .op_i    (a_op_q),
    .idx_i   (a_idx_q),
    .head_i  (head_q),
    .link_i  (link_rd),
    .free_i  (free_q),
    .peak_i  (peak_q),
    .count_i (count_q),
    .size_i  (size_q),
    .base_i  (base_q),
    .head_o  (ex_head),
    .free_o  (ex_free),
    .peak_o  (ex_peak),
    .we_o    (ex_we),
    .waddr_o (ex_waddr),
    .wdata_o (ex_wdata),
    .res_o   (ex_res)
  );

  // Rebuild: highest block at the head, every block free, peak cleared.
  always_comb begin
    head_d = head_q;
    free_d = free_q;
    peak_d = peak_q;
    if (rebuild) begin
      head_d = IW'(cfg_cnt_clamped - CW'(1));
      free_d = cfg_cnt_clamped;
      peak_d = '0;
    end else if (b_fire) begin
      head_d = ex_head;
      free_d = ex_free;
      peak_d = ex_peak;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= IW'(RstCount - CW'(1));
      free_q <= RstCount;
      peak_q <= '0;
    end else begin
      head_q <= head_d;
      free_q <= free_d;
      peak_q <= peak_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  fbfla_pkg::result_t res_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (b_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      res_q <= ex_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q.status;
  assign granted_index_o   = res_q.granted_index;
  assign granted_address_o = res_q.granted_address;
  assign blocks_free_o     = res_q.blocks_free;
  assign blocks_used_o     = res_q.blocks_used;
  assign peak_in_use_o     = res_q.peak_in_use;
  assign all_free_o        = res_q.all_free;
  assign exhausted_o       = res_q.exhausted;

endmodule

### hdl/fbfla_link_mem.sv
// ----------------------------------------------------------------------------
// fbfla_link_mem
// Free-list link store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbfla_link_mem #(
  parameter int unsigned DEPTH = fbfla_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fbfla_exec.sv
// ----------------------------------------------------------------------------
// fbfla_exec
// Single-pass operation logic: pop, push or statistics reset, plus result.
// ----------------------------------------------------------------------------
module fbfla_exec #(
  parameter int unsigned IDX_W = 8
) (
  input  logic [fbfla_pkg::OP_W-1:0]   op_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic [IDX_W-1:0]             head_i,
  input  logic [IDX_W-1:0]             link_i,
  input  logic [fbfla_pkg::CNT_W-1:0]  free_i,
  input  logic [fbfla_pkg::CNT_W-1:0]  peak_i,
  input  logic [fbfla_pkg::CNT_W-1:0]  count_i,
  input  logic [fbfla_pkg::SIZE_W-1:0] size_i,
  input  logic [fbfla_pkg::ADDR_W-1:0] base_i,
  output logic [IDX_W-1:0]             head_o,
  output logic [fbfla_pkg::CNT_W-1:0]  free_o,
  output logic [fbfla_pkg::CNT_W-1:0]  peak_o,
  output logic                         we_o,
  output logic [IDX_W-1:0]             waddr_o,
  output logic [IDX_W-1:0]             wdata_o,
  output fbfla_pkg::result_t           res_o
);

  localparam int unsigned PROD_W = IDX_W + fbfla_pkg::SIZE_W;

  logic [PROD_W-1:0]               prod;
  logic [fbfla_pkg::CNT_W-1:0]     used_pop;
  logic [fbfla_pkg::CNT_W-1:0]     used;
  fbfla_pkg::status_e              status;
  logic                            grant;

  // Offset of the head block; only used on a successful pop.
  assign prod     = PROD_W'(head_i) * PROD_W'(size_i);
  assign used_pop = count_i - (free_i - fbfla_pkg::CNT_W'(1));

  always_comb begin
    head_o = head_i;
    free_o = free_i;
    peak_o = peak_i;
    we_o   = 1'b0;
    status = fbfla_pkg::ST_OK;
    grant  = 1'b0;
    case (fbfla_pkg::op_e'(op_i))
      fbfla_pkg::OP_ALLOC: begin
        if (free_i == '0) begin
          status = fbfla_pkg::ST_EXHAUSTED;
        end else begin
          grant  = 1'b1;
          head_o = link_i;
          free_o = free_i - fbfla_pkg::CNT_W'(1);
          if (used_pop > peak_i) begin
            peak_o = used_pop;
          end
        end
      end
      fbfla_pkg::OP_FREE: begin
        if (free_i >= count_i) begin
          status = fbfla_pkg::ST_NONE_USED;
        end else begin
          we_o   = 1'b1;
          head_o = idx_i;
          free_o = free_i + fbfla_pkg::CNT_W'(1);
        end
      end
      fbfla_pkg::OP_STATS: begin
        peak_o = count_i - free_i;
      end
      default: begin
      end
    endcase
  end

  // Pushed entry links to the old head.
  assign waddr_o = idx_i;
  assign wdata_o = head_i;

  assign used = count_i - free_o;

  always_comb begin
    res_o.status          = status;
    res_o.granted_index   = grant ? fbfla_pkg::GIDX_W'(head_i) : '0;
    res_o.granted_address = grant ? (base_i + fbfla_pkg::ADDR_W'(prod)) : '0;
    res_o.blocks_free     = free_o;
    res_o.blocks_used     = used;
    res_o.peak_in_use     = peak_o;
    res_o.all_free        = (used == '0);
    res_o.exhausted       = (free_o == '0);
  end

endmodule

### hdl/fbfla_checker.sv
// ----------------------------------------------------------------------------
// fbfla_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbfla_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [fbfla_pkg::ST_W-1:0]       status_o,
  input logic [fbfla_pkg::GIDX_W-1:0]     granted_index_o,
  input logic [fbfla_pkg::ADDR_W-1:0]     granted_address_o,
  input logic [fbfla_pkg::CNT_W-1:0]      blocks_free_o,
  input logic [fbfla_pkg::CNT_W-1:0]      blocks_used_o,
  input logic [fbfla_pkg::CNT_W-1:0]      peak_in_use_o
);

  // One item in flight: an accepted item blocks the next edge.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted on consecutive cycles");

  // Failed operations grant nothing.
  a_no_grant_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != fbfla_pkg::ST_OK) |->
      (granted_index_o == '0 && granted_address_o == '0))
    else $error("grant reported on failed operation");

  // Exhausted status only with an empty pool.
  a_exhausted_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == fbfla_pkg::ST_EXHAUSTED) |-> (blocks_free_o == '0))
    else $error("exhausted reported with free blocks");

  // Peak never below current usage.
  a_peak_covers_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_in_use_o >= blocks_used_o))
    else $error("peak below current usage");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(blocks_free_o)
      && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind fixed_block_free_list_allocator_top fbfla_checker u_fbfla_checker (.*);

### verif/tb_fixed_block_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator_top
// Self-checking bench for the block pool allocator. A short directed table
// covers reset state, both error codes, the spare op code, count clamping and
// address wrap. Random phases then reprogram the pool and run fill/drain
// sequences against an in-bench copy of the free list.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator_top;
  import fbfla_pkg::*;

  // Spare op code and spare register index: both must be ignored.
  localparam logic [OP_W-1:0]      OP_NOP     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int unsigned RAND_ITEMS   = 1850;
  localparam int unsigned DRAIN_CYCLES = 8;
  // Time limit, well above the slowest legal run.
  localparam int unsigned RUN_LIMIT    = 4_000_000;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

  // One row of the directed table: an item or a register write.
  typedef struct {
    row_kind_e       kind;
    logic [1:0]      code;   // op code or register index
    logic [31:0]     data;   // block index or write data
    bit              typed;  // expected report written out by hand
    result_t         want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;

  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       op_in;
  logic [BIDX_W-1:0]     blk_in;

  logic                  out_valid;
  logic                  out_ready;
  logic [ST_W-1:0]       res_status;
  logic [GIDX_W-1:0]     res_index;
  logic [ADDR_W-1:0]     res_addr;
  logic [CNT_W-1:0]      res_free;
  logic [CNT_W-1:0]      res_used;
  logic [CNT_W-1:0]      res_peak;
  logic                  res_all_free;
  logic                  res_exhausted;

  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Bench copy of the pool: free list links, head, counts and settings.
  logic [7:0]            next_link [256];
  logic [7:0]            head_blk;
  logic [CNT_W-1:0]      n_free;
  logic [CNT_W-1:0]      peak_seen;
  logic [CNT_W-1:0]      n_blocks;
  logic [SIZE_W-1:0]     blk_size;
  logic [ADDR_W-1:0]     base_addr;

  result_t               reports_due [$];  // pool reports still to come out
  logic [7:0]            live_blocks [$];  // blocks handed out, for tidy frees
  stim_row_t             stim_rows [$];
  bit                    filling;          // stimulus bias: fill or drain
  bit                    quiet;            // no idling on either side
  int unsigned           failures;

  fixed_block_free_list_allocator_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .op_i              (op_in),
    .block_index_i     (blk_in),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (res_status),
    .granted_index_o   (res_index),
    .granted_address_o (res_addr),
    .blocks_free_o     (res_free),
    .blocks_used_o     (res_used),
    .peak_in_use_o     (res_peak),
    .all_free_o        (res_all_free),
    .exhausted_o       (res_exhausted),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT);
    $display("FAIL fixed_block_free_list_allocator_top");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pool predictor
  // --------------------------------------------------------------------------

  // Fresh list: top block first, then descending; link of block zero unused.
  function automatic void pool_rebuild();
    next_link[0] = 8'd0;
    for (int i = 1; i < 256; i++) next_link[i] = 8'(i - 1);
    head_blk  = 8'(n_blocks - 1);
    n_free    = n_blocks;
    peak_seen = '0;
    live_blocks.delete();
    filling   = 1'b1;
  endfunction

  function automatic void pool_config(logic [1:0] which, logic [31:0] value);
    logic [8:0] cnt;
    cnt = value[8:0];
    case (which)
      REG_BLOCK_COUNT: begin
        // Zero is taken as one, anything past the pool depth as the depth.
        if (cnt == 9'd0) cnt = 9'd1;
        else if (cnt > 9'd256) cnt = 9'd256;
        n_blocks = cnt;
        pool_rebuild();
      end
      REG_BLOCK_SIZE: blk_size  = value[SIZE_W-1:0];
      REG_BASE_ADDR:  base_addr = value;
      default: ;
    endcase
  endfunction

  // Applies one item to the bench pool and returns the report it should give.
  function automatic result_t pool_apply_op(logic [1:0] code, logic [7:0] blk);
    result_t    rep;
    logic [8:0] used;
    rep = '0;
    case (code)
      OP_ALLOC: begin
        if (n_free == '0) begin
          rep.status = ST_EXHAUSTED;
        end else begin
          rep.granted_index   = head_blk;
          // 32-bit wrap is intended
          rep.granted_address = base_addr + 32'(head_blk) * 32'(blk_size);
          head_blk = next_link[head_blk];
          n_free   = n_free - 9'd1;
          if (n_blocks - n_free > peak_seen) peak_seen = n_blocks - n_free;
        end
      end
      OP_FREE: begin
        // Double and foreign frees go straight onto the list.
        if (n_free >= n_blocks) begin
          rep.status = ST_NONE_USED;
        end else begin
          next_link[blk] = head_blk;
          head_blk       = blk;
          n_free         = n_free + 9'd1;
        end
      end
      OP_STATS: peak_seen = n_blocks - n_free;
      default: ;
    endcase
    used              = n_blocks - n_free;
    rep.blocks_free   = n_free;
    rep.blocks_used   = used;
    rep.peak_in_use   = peak_seen;
    rep.all_free      = (used == '0);
    rep.exhausted     = (n_free == '0);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int unsigned draw_gap();
    if (quiet) return 0;
    return $urandom_range(0, 5);
  endfunction

  function automatic result_t mk_report(status_e st, logic [7:0] gi, logic [31:0] ga,
                                        logic [8:0] nf, logic [8:0] nu, logic [8:0] pk,
                                        logic af, logic ex);
    result_t rep;
    rep.status          = st;
    rep.granted_index   = gi;
    rep.granted_address = ga;
    rep.blocks_free     = nf;
    rep.blocks_used     = nu;
    rep.peak_in_use     = pk;
    rep.all_free        = af;
    rep.exhausted       = ex;
    return rep;
  endfunction

  function automatic void add_row(row_kind_e kind, logic [1:0] code, logic [31:0] data,
                                  bit typed, result_t want);
    stim_row_t row;
    row.kind  = kind;
    row.code  = code;
    row.data  = data;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  // Sends one item; the report is predicted at the accepting edge.
  task automatic issue_op(logic [1:0] code, logic [7:0] blk, bit typed, result_t want);
    int unsigned gap;
    result_t     due;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_in    <= code;
    blk_in   <= blk;
    do @(posedge clk); while (in_ready !== 1'b1);
    due = pool_apply_op(code, blk);
    if (code == OP_ALLOC && due.status == ST_OK) live_blocks.push_back(due.granted_index);
    reports_due.push_back(typed ? want : due);
  endtask

  // Register writes only once every outstanding report has been taken.
  task automatic write_reg(logic [1:0] which, logic [31:0] value);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pool_config(which, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, each report checked against the oldest
  // one due. The ready draw is made once per item.
  // --------------------------------------------------------------------------
  initial begin : report_checker
    int unsigned gap;
    result_t     want;
    out_ready <= 1'b0;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (reports_due.size() == 0) begin
        $error("report item arrived with none due");
        failures++;
      end else begin
        want = reports_due.pop_front();
        check_field("status",          32'(want.status),          32'(res_status));
        check_field("granted_index",   32'(want.granted_index),   32'(res_index));
        check_field("granted_address", want.granted_address,      res_addr);
        check_field("blocks_free",     32'(want.blocks_free),     32'(res_free));
        check_field("blocks_used",     32'(want.blocks_used),     32'(res_used));
        check_field("peak_in_use",     32'(want.peak_in_use),     32'(res_peak));
        check_field("all_free",        32'(want.all_free),        32'(res_all_free));
        check_field("exhausted",       32'(want.exhausted),       32'(res_exhausted));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    result_t     none;
    int unsigned sent;
    int unsigned n_items;
    int unsigned sel;
    int unsigned r;
    int unsigned pick;
    logic [31:0] cnt_word;
    logic [31:0] size_word;
    logic [31:0] base_word;
    logic [1:0]  code;
    logic [7:0]  blk;

    none      = '0;
    failures  = 0;
    quiet     = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    op_in     <= OP_ALLOC;
    blk_in    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data  <= '0;

    // Bench pool mirrors the reset settings.
    n_blocks  = 9'(RST_BLOCK_CNT);
    blk_size  = RST_BLOCK_SIZE;
    base_addr = RST_BASE_ADDR;
    pool_rebuild();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Reset state: 256 blocks of 64 bytes from address 0.
    add_row(ROW_ITEM, OP_STATS, 32'h00, 1'b1,
            mk_report(ST_OK, 8'd0, 32'h0, 9'd256, 9'd0, 9'd0, 1'b1, 1'b0));
    // free with nothing out is refused
    add_row(ROW_ITEM, OP_FREE, 32'h00, 1'b1,
            mk_report(ST_NONE_USED, 8'd0, 32'h0, 9'd256, 9'd0, 9'd0, 1'b1, 1'b0));
    // top block is handed out first, then the next lower one
    add_row(ROW_ITEM, OP_ALLOC, 32'hFF, 1'b1,
            mk_report(ST_OK, 8'd255, 32'h3FC0, 9'd255, 9'd1, 9'd1, 1'b0, 1'b0));
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b1,
            mk_report(ST_OK, 8'd254, 32'h3F80, 9'd254, 9'd2, 9'd2, 1'b0, 1'b0));
    // spare op code: counts only
    add_row(ROW_ITEM, OP_NOP, 32'hA5, 1'b1,
            mk_report(ST_OK, 8'd0, 32'h0, 9'd254, 9'd2, 9'd2, 1'b0, 1'b0));
    add_row(ROW_ITEM, OP_FREE,  32'hFF, 1'b0, none);
    add_row(ROW_ITEM, OP_STATS, 32'h5A, 1'b0, none);
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b0, none);

    // Count of zero clamps to one; size 65536, top base so the address wraps.
    add_row(ROW_REG, REG_BLOCK_COUNT, 32'd0,          1'b0, none);
    add_row(ROW_REG, REG_BLOCK_SIZE,  32'd65536,      1'b0, none);
    add_row(ROW_REG, REG_BASE_ADDR,   32'hFFFF_FFFF,  1'b0, none);
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b1,
            mk_report(ST_OK, 8'd0, 32'hFFFF_FFFF, 9'd0, 9'd1, 9'd1, 1'b0, 1'b1));
    // empty pool: refused, nothing moves
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b1,
            mk_report(ST_EXHAUSTED, 8'd0, 32'h0, 9'd0, 9'd1, 9'd1, 1'b0, 1'b1));
    add_row(ROW_ITEM, OP_FREE,  32'h00, 1'b0, none);
    add_row(ROW_ITEM, OP_FREE,  32'h00, 1'b0, none);
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b0, none);
    // foreign index goes onto the list and comes back out
    add_row(ROW_ITEM, OP_FREE,  32'd200, 1'b0, none);
    add_row(ROW_ITEM, OP_ALLOC, 32'h00,  1'b0, none);
    add_row(ROW_ITEM, OP_STATS, 32'h00,  1'b0, none);

    // Count above the depth clamps; block size below a pointer is kept as is.
    add_row(ROW_REG, REG_BLOCK_COUNT, 32'd300,        1'b0, none);
    add_row(ROW_REG, REG_BLOCK_SIZE,  32'd3,          1'b0, none);
    add_row(ROW_REG, REG_BASE_ADDR,   32'h8000_0000,  1'b0, none);
    add_row(ROW_REG, REG_UNUSED,      32'h5A5A_5A5A,  1'b0, none);
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b0, none);
    // double free of a block that was never taken
    add_row(ROW_ITEM, OP_FREE,  32'h00, 1'b0, none);
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b0, none);
    add_row(ROW_ITEM, OP_FREE,  32'hFF, 1'b0, none);
    add_row(ROW_ITEM, OP_STATS, 32'h00, 1'b0, none);
    add_row(ROW_ITEM, OP_ALLOC, 32'h00, 1'b0, none);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG)
        write_reg(stim_rows[i].code, stim_rows[i].data);
      else
        issue_op(stim_rows[i].code, stim_rows[i].data[7:0], stim_rows[i].typed,
                 stim_rows[i].want);
    end

    // Random phases: new settings each time, then fill/drain runs.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);

      sel = $urandom_range(0, 7);
      if (sel == 0)      size_word = 32'd8;
      else if (sel == 1) size_word = 32'd65536;
      else if (sel == 2) size_word = $urandom;  // upper bits dropped by the block
      else               size_word = $urandom_range(8, 65536);
      write_reg(REG_BLOCK_SIZE, size_word);

      sel = $urandom_range(0, 5);
      if (sel == 0)      base_word = 32'h0;
      else if (sel == 1) base_word = 32'hFFFF_FFFF;
      else               base_word = $urandom;
      write_reg(REG_BASE_ADDR, base_word);

      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);

      // Mostly small pools so that exhaustion comes often.
      sel = $urandom_range(0, 9);
      if (sel < 6)       cnt_word = $urandom_range(1, 16);
      else if (sel < 8)  cnt_word = $urandom_range(17, 256);
      else if (sel == 8) cnt_word = 32'd256;
      else begin
        cnt_word      = $urandom & 32'hFFFF_FE00;
        cnt_word[8:0] = ($urandom_range(0, 1) == 0) ? 9'd0 : 9'($urandom_range(257, 511));
      end
      write_reg(REG_BLOCK_COUNT, cnt_word);

      n_items = 3 * n_blocks + $urandom_range(20, 80);
      if (n_items > RAND_ITEMS - sent + 20) n_items = RAND_ITEMS - sent + 20;

      repeat (n_items) begin
        r    = $urandom_range(0, 99);
        blk  = 8'($urandom);
        if (r < 3)      code = OP_STATS;
        else if (r < 5) code = OP_NOP;
        else if (r < 8) code = OP_FREE;   // stray index
        else if ((r < 80) == filling) code = OP_ALLOC;
        else begin
          // tidy free of a block actually handed out
          code = OP_FREE;
          if (live_blocks.size() != 0) begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            blk  = live_blocks[pick];
            live_blocks.delete(pick);
          end
        end
        issue_op(code, blk, 1'b0, none);
        sent++;
        if (n_free == '0) filling = 1'b0;
        else if (n_free == n_blocks) filling = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("PASS fixed_block_free_list_allocator_top");
    else
      $display("FAIL fixed_block_free_list_allocator_top");
    $finish;
  end

endmodule

### sim.f
hdl/fbfla_pkg.sv
hdl/fbfla_link_mem.sv
hdl/fbfla_exec.sv
hdl/fixed_block_free_list_allocator_top.sv
hdl/fbfla_checker.sv
verif/tb_fixed_block_free_list_allocator_top.sv
